[rtl/gfr_pkg.sv]
// Shared types and constants for the face removal step block.
`default_nettype none
package gfr_pkg;

  localparam int MAX_FACES  = 64;
  localparam int MAX_NB     = 6;
  localparam int SLOT_TOTAL = MAX_FACES * MAX_NB;
  localparam int ADDR_W     = $clog2(SLOT_TOTAL);
  localparam int FACE_W     = 6;
  localparam int CNT_W      = 7;
  localparam int RATE_W     = 24;
  localparam int KSUM_W     = 30;

  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_EVENT = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_ACK   = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic [2:0] CFG_FACE_COUNT = 3'd0;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [FACE_W-1:0] face_index;
    logic [2:0]        slot;
    logic [FACE_W-1:0] neighbour_face;
    logic              slot_used;
    logic [31:0]       uniform_time;
    logic [31:0]       uniform_pick;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [FACE_W-1:0] removed_face;
    logic [2:0]        bonds_broken;
    logic [CNT_W-1:0]  faces_left;
    logic [7:0]        bonds_left;
    logic [31:0]       delta_time;
    logic              all_removed;
  } out_item_t;

  typedef struct packed {
    logic              face_v;
    logic              done;
    logic [FACE_W-1:0] face;
    logic [2:0]        m;
    logic [2:0]        up;
  } walk_t;

endpackage
`default_nettype wire

[rtl/gfr_walk.sv]
// Adjacency memory and face walker counting live neighbours per face.
`default_nettype none
module gfr_walk (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            wr_en,
  input  wire [gfr_pkg::ADDR_W-1:0]      wr_addr,
  input  wire [6:0]                      wr_data,
  input  wire                            go,
  input  wire [gfr_pkg::CNT_W-1:0]       n,
  input  wire [gfr_pkg::MAX_FACES-1:0]   mask,
  output gfr_pkg::walk_t                 walk
);

  logic [6:0] mem [gfr_pkg::SLOT_TOTAL];
  logic [6:0] rd_r;

  logic                         run_r;
  logic [gfr_pkg::CNT_W-1:0]    face_r;
  logic [2:0]                   slot_r;
  logic [gfr_pkg::ADDR_W-1:0]   addr_r;
  logic                         v1_r;
  logic [gfr_pkg::FACE_W-1:0]   face1_r;
  logic                         slast1_r;
  logic                         flast1_r;
  logic [2:0]                   m_acc_r;
  logic [2:0]                   up_acc_r;
  gfr_pkg::walk_t               walk_r;

  logic       live;
  logic       up;
  logic [2:0] m_sum;
  logic [2:0] up_sum;
  logic       slot_end;
  logic       face_end;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[addr_r];
  end

  assign slot_end = (slot_r == 3'(gfr_pkg::MAX_NB - 1));
  assign face_end = ((face_r + 7'd1) == n);

  assign live   = rd_r[6] && ({1'b0, rd_r[5:0]} < n) && mask[rd_r[5:0]];
  assign up     = live && (rd_r[5:0] > face1_r);
  assign m_sum  = m_acc_r + {2'b0, live};
  assign up_sum = up_acc_r + {2'b0, up};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      face_r   <= '0;
      slot_r   <= '0;
      addr_r   <= '0;
      v1_r     <= 1'b0;
      m_acc_r  <= '0;
      up_acc_r <= '0;
      walk_r   <= '0;
    end else begin
      if (go) begin
        run_r  <= (n != '0);
        face_r <= '0;
        slot_r <= '0;
        addr_r <= '0;
      end else if (run_r) begin
        addr_r <= addr_r + 1'b1;
        if (slot_end) begin
          slot_r <= '0;
          face_r <= face_r + 7'd1;
          if (face_end) begin
            run_r <= 1'b0;
          end
        end else begin
          slot_r <= slot_r + 3'd1;
        end
      end
      v1_r     <= run_r && !go;
      face1_r  <= face_r[gfr_pkg::FACE_W-1:0];
      slast1_r <= slot_end;
      flast1_r <= face_end;
      if (v1_r) begin
        m_acc_r  <= slast1_r ? 3'd0 : m_sum;
        up_acc_r <= slast1_r ? 3'd0 : up_sum;
      end
      walk_r.face_v <= v1_r && slast1_r;
      walk_r.done   <= (v1_r && slast1_r && flast1_r) || (go && (n == '0));
      walk_r.face   <= face1_r;
      walk_r.m      <= m_sum;
      walk_r.up     <= up_sum;
    end
  end

  assign walk = walk_r;

endmodule
`default_nettype wire

[rtl/gfr_time.sv]
// Waiting time unit: normalise, log by squaring, scale by ln2, divide by the rate sum.
`default_nettype none
module gfr_time (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         go,
  input  wire [31:0]                  u1,
  input  wire [gfr_pkg::KSUM_W-1:0]   k,
  output logic                        ready,
  output logic [31:0]                 dt
);

  typedef enum logic [6:0] {
    T_IDLE = 7'b0000001,
    T_NORM = 7'b0000010,
    T_LOG  = 7'b0000100,
    T_SUB  = 7'b0001000,
    T_MLO  = 7'b0010000,
    T_MHI  = 7'b0100000,
    T_DIV  = 7'b1000000
  } tstate_t;

  tstate_t                     state_r;
  logic                        ready_r;
  logic [31:0]                 dt_r;
  logic [31:0]                 x_r;
  logic [5:0]                  z_r;
  logic [31:0]                 f_r;
  logic [5:0]                  cnt_r;
  logic [37:0]                 nl_r;
  logic [63:0]                 p_r;
  logic [37:0]                 ln_r;
  logic [gfr_pkg::KSUM_W-1:0]  rem_r;
  logic [gfr_pkg::KSUM_W-1:0]  k_r;

  logic [63:0]                 sq;
  logic [32:0]                 ys;
  logic [gfr_pkg::KSUM_W:0]    remsh;
  logic                        ge;
  logic [37:0]                 q_nxt;

  assign sq    = x_r * x_r;
  assign ys    = sq[63:31];
  assign remsh = {rem_r, ln_r[37]};
  assign ge    = (remsh >= {1'b0, k_r});
  assign q_nxt = {ln_r[36:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      ready_r <= 1'b0;
    end else begin
      unique case (state_r)
        T_IDLE: begin
          if (go) begin
            k_r <= k;
            x_r <= u1;
            z_r <= '0;
            if (u1 == '0 || k == '0) begin
              dt_r    <= 32'hFFFFFFFF;
              ready_r <= 1'b1;
            end else begin
              ready_r <= 1'b0;
              state_r <= T_NORM;
            end
          end
        end
        T_NORM: begin
          if (x_r[31]) begin
            f_r     <= '0;
            cnt_r   <= '0;
            state_r <= T_LOG;
          end else begin
            x_r <= {x_r[30:0], 1'b0};
            z_r <= z_r + 6'd1;
          end
        end
        T_LOG: begin
          if (ys[32]) begin
            x_r <= ys[32:1];
            f_r <= {f_r[30:0], 1'b1};
          end else begin
            x_r <= ys[31:0];
            f_r <= {f_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd31) begin
            state_r <= T_SUB;
          end
        end
        T_SUB: begin
          nl_r    <= {z_r + 6'd1, 32'b0} - {6'b0, f_r};
          state_r <= T_MLO;
        end
        T_MLO: begin
          p_r     <= 64'(nl_r[31:0]) * 64'(gfr_pkg::LN2_Q32);
          state_r <= T_MHI;
        end
        T_MHI: begin
          ln_r    <= 38'(38'(nl_r[37:32]) * 38'(gfr_pkg::LN2_Q32)) + 38'(p_r[63:32]);
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= T_DIV;
        end
        T_DIV: begin
          rem_r <= ge ? gfr_pkg::KSUM_W'(remsh - {1'b0, k_r})
                      : remsh[gfr_pkg::KSUM_W-1:0];
          ln_r  <= q_nxt;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd37) begin
            dt_r    <= (q_nxt[37:32] != '0) ? 32'hFFFFFFFF : q_nxt[31:0];
            ready_r <= 1'b1;
            state_r <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign ready = ready_r;
  assign dt    = dt_r;

endmodule
`default_nettype wire

[rtl/gillespie_face_removal_step.sv]
// Top level: command sequencer, trajectory state and result register.
`default_nettype none
// A load is written when taken and its acknowledge appears in the cycle after. A
// start walks every slot of the n faces in use through the adjacency memory, one
// read a cycle, and reports once the walk is done. An event walks the memory twice
// (rate sum, then choice): with no face present it reports after the first walk,
// otherwise once both the second walk and the waiting time unit, started with the
// second walk, are finished. The time that unit takes is set by the normalising
// shift (z leading zeros of the draw), the 32-step log and the 38-step divider; a
// zero draw or zero rate sum skips these. Results are strobed for one cycle on
// out_valid and cannot be held off; busy is high while an item is at work, and a
// new item is taken while the last result is shown.
module gillespie_face_removal_step (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  gfr_pkg::in_item_t  in_data,
  output logic               out_valid,
  output gfr_pkg::out_item_t out_data,
  input  wire                cfg_we,
  input  wire [2:0]          cfg_index,
  input  wire [23:0]         cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_SUM   = 6'b000100,
    S_MUL   = 6'b001000,
    S_PICK  = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [gfr_pkg::CNT_W-1:0]     face_count_r;
  logic [gfr_pkg::RATE_W-1:0]    rate_r [0:6];
  logic [gfr_pkg::MAX_FACES-1:0] mask_r, mask_nxt;
  logic [gfr_pkg::CNT_W-1:0]     faces_r, faces_nxt;
  logic [7:0]                    bonds_r, bonds_nxt;
  logic [31:0]                   u1_r, u1_nxt;
  logic [31:0]                   u2_r, u2_nxt;
  logic [gfr_pkg::KSUM_W-1:0]    k_r, k_nxt;
  logic [gfr_pkg::KSUM_W-1:0]    sum_r, sum_nxt;
  logic [61:0]                   target_r, target_nxt;
  logic                          any_r, any_nxt;
  logic                          found_r, found_nxt;
  logic [gfr_pkg::FACE_W-1:0]    first_r, first_nxt;
  logic [2:0]                    first_m_r, first_m_nxt;
  logic [gfr_pkg::FACE_W-1:0]    chosen_r, chosen_nxt;
  logic [2:0]                    chosen_m_r, chosen_m_nxt;
  logic                          out_valid_r, out_valid_nxt;
  gfr_pkg::out_item_t            out_r, out_nxt;

  logic [gfr_pkg::CNT_W-1:0]     n_w;
  logic                          accept;
  logic                          walk_go;
  logic                          wr_en;
  logic [gfr_pkg::ADDR_W-1:0]    wr_addr;
  gfr_pkg::walk_t                walk;
  logic [gfr_pkg::RATE_W-1:0]    rate_sel;
  logic                          present;
  logic                          t_go;
  logic                          t_ready;
  logic [31:0]                   t_dt;
  logic [8:0]                    b_sum;

  assign n_w    = (face_count_r > 7'(gfr_pkg::MAX_FACES)) ? 7'(gfr_pkg::MAX_FACES)
                                                          : face_count_r;
  assign busy   = !(state_r == S_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (in_data.cmd == gfr_pkg::CMD_LOAD) &&
                  (in_data.slot < 3'(gfr_pkg::MAX_NB));
  assign wr_addr = gfr_pkg::ADDR_W'({3'b0, in_data.face_index} * 9'(gfr_pkg::MAX_NB)) +
                   gfr_pkg::ADDR_W'(in_data.slot);
  assign present = mask_r[walk.face];
  assign b_sum   = {1'b0, bonds_r} + {6'b0, walk.up};

  always_comb begin
    case (walk.m)
      3'd0:    rate_sel = rate_r[0];
      3'd1:    rate_sel = rate_r[1];
      3'd2:    rate_sel = rate_r[2];
      3'd3:    rate_sel = rate_r[3];
      3'd4:    rate_sel = rate_r[4];
      3'd5:    rate_sel = rate_r[5];
      default: rate_sel = rate_r[6];
    endcase
  end

  gfr_walk u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({in_data.slot_used, in_data.neighbour_face}),
    .go      (walk_go),
    .n       (n_w),
    .mask    (mask_nxt),
    .walk    (walk)
  );

  gfr_time u_time (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (t_go),
    .u1    (u1_r),
    .k     (k_r),
    .ready (t_ready),
    .dt    (t_dt)
  );

  always_comb begin
    state_nxt     = state_r;
    mask_nxt      = mask_r;
    faces_nxt     = faces_r;
    bonds_nxt     = bonds_r;
    u1_nxt        = u1_r;
    u2_nxt        = u2_r;
    k_nxt         = k_r;
    sum_nxt       = sum_r;
    target_nxt    = target_r;
    any_nxt       = any_r;
    found_nxt     = found_r;
    first_nxt     = first_r;
    first_m_nxt   = first_m_r;
    chosen_nxt    = chosen_r;
    chosen_m_nxt  = chosen_m_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    walk_go       = 1'b0;
    t_go          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.cmd)
            gfr_pkg::CMD_LOAD: begin
              out_valid_nxt  = 1'b1;
              out_nxt        = '0;
              out_nxt.status = gfr_pkg::STAT_ACK;
            end
            gfr_pkg::CMD_START: begin
              for (int i = 0; i < gfr_pkg::MAX_FACES; i++) begin
                mask_nxt[i] = (7'(i) < n_w);
              end
              faces_nxt = n_w;
              bonds_nxt = '0;
              walk_go   = 1'b1;
              state_nxt = S_START;
            end
            gfr_pkg::CMD_EVENT: begin
              u1_nxt    = in_data.uniform_time;
              u2_nxt    = in_data.uniform_pick;
              k_nxt     = '0;
              any_nxt   = 1'b0;
              walk_go   = 1'b1;
              state_nxt = S_SUM;
            end
            default: begin
            end
          endcase
        end
      end
      S_START: begin
        if (walk.face_v) begin
          bonds_nxt = b_sum[8] ? 8'hFF : b_sum[7:0];
        end
        if (walk.done) begin
          out_valid_nxt      = 1'b1;
          out_nxt            = '0;
          out_nxt.status     = gfr_pkg::STAT_ACK;
          out_nxt.faces_left = faces_r;
          out_nxt.bonds_left = bonds_nxt;
          state_nxt          = S_IDLE;
        end
      end
      S_SUM: begin
        if (walk.face_v && present) begin
          k_nxt = k_r + gfr_pkg::KSUM_W'(rate_sel);
          if (!any_r) begin
            first_nxt   = walk.face;
            first_m_nxt = walk.m;
          end
          any_nxt = 1'b1;
        end
        if (walk.done) begin
          if (!any_nxt) begin
            out_valid_nxt      = 1'b1;
            out_nxt            = '0;
            out_nxt.status     = gfr_pkg::STAT_EMPTY;
            out_nxt.faces_left = faces_r;
            out_nxt.bonds_left = bonds_r;
            state_nxt          = S_IDLE;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        target_nxt = 62'(u2_r) * 62'(k_r);
        t_go       = 1'b1;
        walk_go    = 1'b1;
        sum_nxt    = '0;
        found_nxt  = 1'b0;
        state_nxt  = S_PICK;
      end
      S_PICK: begin
        if (walk.face_v && present && !found_r) begin
          sum_nxt = sum_r + gfr_pkg::KSUM_W'(rate_sel);
          if (target_r <= {sum_nxt, 32'b0}) begin
            found_nxt    = 1'b1;
            chosen_nxt   = walk.face;
            chosen_m_nxt = walk.m;
          end
        end
        if (walk.done) begin
          if (!found_nxt) begin
            chosen_nxt   = first_r;
            chosen_m_nxt = first_m_r;
          end
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (t_ready) begin
          mask_nxt[chosen_r] = 1'b0;
          bonds_nxt = (bonds_r > {5'b0, chosen_m_r}) ? bonds_r - {5'b0, chosen_m_r} : '0;
          faces_nxt = (faces_r != '0) ? faces_r - 7'd1 : '0;
          out_valid_nxt        = 1'b1;
          out_nxt.status       = gfr_pkg::STAT_OK;
          out_nxt.removed_face = chosen_r;
          out_nxt.bonds_broken = chosen_m_r;
          out_nxt.faces_left   = faces_nxt;
          out_nxt.bonds_left   = bonds_nxt;
          out_nxt.delta_time   = t_dt;
          out_nxt.all_removed  = (faces_nxt == '0);
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mask_r       <= '0;
      faces_r      <= '0;
      bonds_r      <= '0;
      out_valid_r  <= 1'b0;
      any_r        <= 1'b0;
      found_r      <= 1'b0;
      face_count_r <= 7'd20;
      for (int i = 0; i < 7; i++) begin
        rate_r[i] <= 24'h010000;
      end
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      faces_r     <= faces_nxt;
      bonds_r     <= bonds_nxt;
      out_valid_r <= out_valid_nxt;
      any_r       <= any_nxt;
      found_r     <= found_nxt;
      if (cfg_we) begin
        case (cfg_index)
          gfr_pkg::CFG_FACE_COUNT: face_count_r <= cfg_data[6:0];
          default:                 rate_r[3'(cfg_index - 3'd1)] <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    u1_r       <= u1_nxt;
    u2_r       <= u2_nxt;
    k_r        <= k_nxt;
    sum_r      <= sum_nxt;
    target_r   <= target_nxt;
    first_r    <= first_nxt;
    first_m_r  <= first_m_nxt;
    chosen_r   <= chosen_nxt;
    chosen_m_r <= chosen_m_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    faces_r <= 7'(gfr_pkg::MAX_FACES))
    else $error("face count beyond table size");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT && t_ready) |=> out_valid)
    else $error("event finished without a result");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == gfr_pkg::STAT_EMPTY) |->
      (out_data.removed_face == '0 && out_data.delta_time == '0))
    else $error("empty status carries event fields");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK && walk.done) |=> (mask_r[chosen_r]))
    else $error("chosen face is not present");

endmodule
`default_nettype wire
